### hdl/srnf_pkg.sv
// ============================================================================
// srnf_pkg
// Shared types and constants of the stream raster node finder: field widths,
// register indexes, D8 step tables and the words passed between stages.
// ============================================================================
package srnf_pkg;

    localparam int DIR_BITS      = 5;
    localparam int FIELD_BITS    = 16;
    localparam int CELL_COL_BITS = 12;
    localparam int COUNT_BITS    = 4;
    localparam int TRIB_SLOTS    = 4;
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 136;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_STREAM_LIMIT = 2'd2;

    // D8 row and column steps, index 1 = NE counter-clockwise to 8 = E
    localparam logic signed [1:0] STEP_ROW [0:8] = '{
        2'sb00, 2'sb11, 2'sb11, 2'sb11, 2'sb00, 2'sb01, 2'sb01, 2'sb01, 2'sb00
    };
    localparam logic signed [1:0] STEP_COL [0:8] = '{
        2'sb00, 2'sb01, 2'sb00, 2'sb11, 2'sb11, 2'sb11, 2'sb00, 2'sb01, 2'sb01
    };

    // direction a neighbor must carry to drain into the center cell
    localparam logic [DIR_BITS-1:0] DIR_OPPOSITE [1:8] = '{
        5'd5, 5'd6, 5'd7, 5'd8, 5'd1, 5'd2, 5'd3, 5'd4
    };

    // position of the cell reported for one word
    typedef struct packed {
        logic        frame_last;
        logic        have_q;
        logic [15:0] qr;
        logic [15:0] qc;
    } pos_tag_t;

    // neighborhood result ahead of the frame counters
    typedef struct packed {
        logic                                frame_last;
        logic                                produce;
        logic [FIELD_BITS-1:0]               row;
        logic [CELL_COL_BITS-1:0]            col;
        logic [FIELD_BITS-1:0]               own_label;
        logic [FIELD_BITS-1:0]               downstream_label;
        logic [COUNT_BITS-1:0]               inflow_count;
        logic [TRIB_SLOTS-1:0][FIELD_BITS-1:0] tributary;
        logic                                trib_overflow;
    } node_t;

endpackage

### hdl/stream_raster_node_finder_unit.sv
// ============================================================================
// stream_raster_node_finder_unit
// D8 stream node finder over a raster streamed in row order.
//
//   channel   dir  handshake         word
//   s_axis    in   tvalid / tready   tdata: label, flow_dir; tuser: pad
//   m_axis    out  tvalid / tready   tdata: one stream cell node record
//   apb       in   psel / penable    row_count, column_count, stream_limit
//
// One word per cycle sustained while m_axis takes results; the column memory
// is read for the new word and written for the previous one in the same cycle.
// The word column_count+1 words after a cell completes its 3x3 window; once
// accepted, the result passes window, node and output registers to m_axis.
// Reset clears the counters and valid flags; the column memory needs no
// clearing, every cell read inside the raster is written in the same frame.
// A stall on m_axis fills the four stages before s_axis_tready drops.
// ============================================================================
module stream_raster_node_finder_unit
    import srnf_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int LABEL_BITS  = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // stream_label, flow_dir
    input  logic [0:0]               s_axis_tuser,   // pad
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // cell_row, cell_col, own_label, downstream_label, is_spring,
    // inflow_count, tributary_one..tributary_four, error_flag
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int COL_BITS = $clog2(MAX_COLUMNS);
    localparam int CNT_BITS = COL_BITS + 1;
    localparam int LW       = (LABEL_BITS < FIELD_BITS) ? LABEL_BITS : FIELD_BITS;

    logic [15:0] row_count_reg;
    logic [12:0] column_count_reg;
    logic [15:0] stream_limit_reg;
    logic [16:0]         row_reg;
    logic [16:0]         row_next;
    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] col_next;

    logic                cfg_wr;
    logic                restart;
    logic [15:0]         rows_eff;
    logic [CNT_BITS-1:0] cols_eff;
    logic                accept;
    logic                store_zero;
    logic                col_nz;
    logic [16:0]         qr;
    logic [COL_BITS-1:0] qc;
    logic [CNT_BITS-1:0] col_inc;
    pos_tag_t            tag;
    logic [LW-1:0]       cell_lab;
    logic [DIR_BITS-1:0] cell_dir;

    logic                     lb_valid;
    logic                     win_ready;
    logic [2:0][LW-1:0]       lb_lab;
    logic [2:0][DIR_BITS-1:0] lb_dir;
    pos_tag_t                 lb_tag;
    logic                     node_valid;
    logic                     out_ready;
    node_t                    node;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign restart = cfg_wr && ((paddr[3:2] == REG_ROW_COUNT) ||
                                (paddr[3:2] == REG_COLUMN_COUNT) ||
                                (paddr[3:2] == REG_STREAM_LIMIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 16'd1;
            column_count_reg <= 13'd1;
            stream_limit_reg <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROW_COUNT:    row_count_reg    <= pwdata[15:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[12:0];
                REG_STREAM_LIMIT: stream_limit_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROW_COUNT:    prdata = {16'b0, row_count_reg};
            REG_COLUMN_COUNT: prdata = {19'b0, column_count_reg};
            REG_STREAM_LIMIT: prdata = {16'b0, stream_limit_reg};
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        rows_eff = (row_count_reg == '0) ? 16'd1 : row_count_reg;
        if (column_count_reg == '0)
            cols_eff = CNT_BITS'(1);
        else if (32'(column_count_reg) > 32'(MAX_COLUMNS))
            cols_eff = CNT_BITS'(MAX_COLUMNS);
        else
            cols_eff = CNT_BITS'(column_count_reg);
    end

    // ---- raster position of the incoming word ----
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign store_zero = s_axis_tuser[0] || (row_reg >= {1'b0, rows_eff});
    assign cell_lab   = store_zero ? '0 : s_axis_tdata[LW-1:0];
    assign cell_dir   = store_zero ? '0 : s_axis_tdata[FIELD_BITS+DIR_BITS-1:FIELD_BITS];
    assign col_nz     = col_reg != '0;
    assign qr         = col_nz ? (row_reg - 17'd1) : (row_reg - 17'd2);
    assign qc         = col_nz ? (col_reg - COL_BITS'(1))
                               : COL_BITS'(cols_eff - CNT_BITS'(1));
    assign col_inc    = {1'b0, col_reg} + CNT_BITS'(1);

    always_comb
    begin
        tag.have_q     = (row_reg != '0) && (col_nz || (row_reg >= 17'd2));
        tag.qr         = qr[15:0];
        tag.qc         = 16'(qc);
        tag.frame_last = tag.have_q && (qr == {1'b0, rows_eff - 16'd1}) &&
                         (qc == COL_BITS'(cols_eff - CNT_BITS'(1)));
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (tag.frame_last)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_inc >= cols_eff)
            begin
                row_next = row_reg + 17'd1;
                col_next = '0;
            end
            else
            begin
                col_next = col_inc[COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---- datapath ----
    srnf_line_buffer #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .LW          (LW),
        .COL_BITS    (COL_BITS)
    ) u_line_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_lab    (cell_lab),
        .in_dir    (cell_dir),
        .in_addr   (col_reg),
        .in_tag    (tag),
        .out_valid (lb_valid),
        .out_ready (win_ready),
        .out_lab   (lb_lab),
        .out_dir   (lb_dir),
        .out_tag   (lb_tag)
    );

    srnf_window #(
        .LW       (LW),
        .CNT_BITS (CNT_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lb_valid),
        .in_ready  (win_ready),
        .in_lab    (lb_lab),
        .in_dir    (lb_dir),
        .in_tag    (lb_tag),
        .rows      (rows_eff),
        .cols      (cols_eff),
        .out_valid (node_valid),
        .out_ready (out_ready),
        .out_node  (node)
    );

    srnf_node_out u_node_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (node_valid),
        .in_ready      (out_ready),
        .in_node       (node),
        .stream_limit  (stream_limit_reg),
        .restart       (restart),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### hdl/srnf_line_buffer.sv
// ============================================================================
// srnf_line_buffer
// Column memory holding the two previous raster rows. Each word reads its
// column, the stage after writes the shifted column back.
// ============================================================================
module srnf_line_buffer
    import srnf_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int LW          = 16,
    parameter int COL_BITS    = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LW-1:0]                 in_lab,
    input  logic [DIR_BITS-1:0]           in_dir,
    input  logic [COL_BITS-1:0]           in_addr,
    input  pos_tag_t                      in_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0][LW-1:0]            out_lab,
    output logic [2:0][DIR_BITS-1:0]      out_dir,
    output pos_tag_t                      out_tag
);

    localparam int CELL = LW + DIR_BITS;
    localparam int WORD = 2 * CELL;

    logic [WORD-1:0]     mem [0:MAX_COLUMNS-1];
    logic [WORD-1:0]     rd_data_reg;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [LW-1:0]       s1_lab_reg;
    logic [DIR_BITS-1:0] s1_dir_reg;
    logic [COL_BITS-1:0] s1_addr_reg;
    pos_tag_t            s1_tag_reg;
    logic                byp_reg;
    logic [WORD-1:0]     byp_data_reg;

    logic            accept;
    logic            advance;
    logic [WORD-1:0] line_word;
    logic [CELL-1:0] row1_cell;
    logic [CELL-1:0] row2_cell;
    logic [WORD-1:0] wr_word;

    assign advance  = s1_valid_reg && out_ready;
    assign in_ready = !s1_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // a write to the column being read in the same cycle is forwarded
    assign line_word = byp_reg ? byp_data_reg : rd_data_reg;
    assign row1_cell = line_word[CELL-1:0];
    assign row2_cell = line_word[WORD-1:CELL];
    assign wr_word   = {row1_cell, s1_dir_reg, s1_lab_reg};

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            mem[s1_addr_reg] <= wr_word;
        if (accept)
            rd_data_reg <= mem[in_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
                byp_reg <= advance && (in_addr == s1_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lab_reg   <= in_lab;
            s1_dir_reg   <= in_dir;
            s1_addr_reg  <= in_addr;
            s1_tag_reg   <= in_tag;
            byp_data_reg <= wr_word;
        end
    end

    assign out_valid  = s1_valid_reg;
    assign out_tag    = s1_tag_reg;
    assign out_lab[0] = row2_cell[LW-1:0];
    assign out_dir[0] = row2_cell[CELL-1:LW];
    assign out_lab[1] = row1_cell[LW-1:0];
    assign out_dir[1] = row1_cell[CELL-1:LW];
    assign out_lab[2] = s1_lab_reg;
    assign out_dir[2] = s1_dir_reg;

endmodule

### hdl/srnf_window.sv
// ============================================================================
// srnf_window
// 3x3 window of cells and the neighborhood logic: inflowing neighbors,
// tributary labels in D8 order and the downstream label.
// ============================================================================
module srnf_window
    import srnf_pkg::*;
#(
    parameter int LW       = 16,
    parameter int CNT_BITS = 13
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0][LW-1:0]       in_lab,
    input  logic [2:0][DIR_BITS-1:0] in_dir,
    input  pos_tag_t                 in_tag,
    input  logic [15:0]              rows,
    input  logic [CNT_BITS-1:0]      cols,
    output logic                     out_valid,
    input  logic                     out_ready,
    output node_t                    out_node
);

    // [column][row], column 0 = west, row 0 = north
    logic [2:0][2:0][LW-1:0]       win_lab_reg;
    logic [2:0][2:0][DIR_BITS-1:0] win_dir_reg;
    logic                          w_valid_reg;
    logic                          w_valid_next;
    pos_tag_t                      w_tag_reg;
    logic                          c_valid_reg;
    logic                          c_valid_next;
    node_t                         c_node_reg;

    logic c_free;
    logic w_adv;
    logic shift;

    logic                top_ok;
    logic                bot_ok;
    logic                left_ok;
    logic                right_ok;
    logic [LW-1:0]       nb_lab [1:8];
    logic [DIR_BITS-1:0] nb_dir [1:8];
    logic [8:1]          nb_ok;
    logic [8:1]          inflow;
    logic [COUNT_BITS-1:0]                 cnt;
    logic [TRIB_SLOTS-1:0][FIELD_BITS-1:0] trib;
    logic [LW-1:0]       own;
    logic [DIR_BITS-1:0] own_dir;
    logic [DIR_BITS-1:0] abs_dir;
    logic [FIELD_BITS-1:0] down;
    node_t               node;

    assign c_free   = !c_valid_reg || out_ready;
    assign w_adv    = w_valid_reg && c_free;
    assign in_ready = !w_valid_reg || c_free;
    assign shift    = in_valid && in_ready;

    always_comb
    begin
        int ri;
        int ci;
        logic rok;
        logic cok;
        logic [3:0] rank;
        top_ok   = w_tag_reg.qr != '0;
        bot_ok   = ({1'b0, w_tag_reg.qr} + 17'd1) < {1'b0, rows};
        left_ok  = w_tag_reg.qc != '0;
        right_ok = ({1'b0, w_tag_reg.qc} + 17'd1) < 17'(cols);
        cnt  = '0;
        trib = '0;
        rank = '0;
        down = '0;
        own     = win_lab_reg[1][1];
        own_dir = win_dir_reg[1][1];
        abs_dir = own_dir[DIR_BITS-1] ? (~own_dir + 5'd1) : own_dir;
        for (int d = 1; d <= 8; d++)
        begin
            ri = 1 + int'(STEP_ROW[d]);
            ci = 1 + int'(STEP_COL[d]);
            nb_lab[d] = win_lab_reg[ci][ri];
            nb_dir[d] = win_dir_reg[ci][ri];
            if (STEP_ROW[d] == 2'sb11)
                rok = top_ok;
            else if (STEP_ROW[d] == 2'sb01)
                rok = bot_ok;
            else
                rok = 1'b1;
            if (STEP_COL[d] == 2'sb11)
                cok = left_ok;
            else if (STEP_COL[d] == 2'sb01)
                cok = right_ok;
            else
                cok = 1'b1;
            nb_ok[d]  = rok && cok;
            inflow[d] = nb_ok[d] && (nb_lab[d] != '0) && (nb_dir[d] == DIR_OPPOSITE[d]);
            cnt = cnt + COUNT_BITS'(inflow[d]);
            if (inflow[d])
            begin
                if (rank < 4'd4)
                    trib[rank[1:0]] = FIELD_BITS'(nb_lab[d]);
                rank = rank + 4'd1;
            end
            // a direction magnitude above 8 matches no neighbor
            if ((abs_dir == DIR_BITS'(d)) && nb_ok[d] && (nb_lab[d] != '0))
                down = FIELD_BITS'(nb_lab[d]);
        end
        if (cnt < 4'd2)
            trib = '0;
        node.frame_last       = w_tag_reg.frame_last;
        node.produce          = w_tag_reg.have_q && (own != '0);
        node.row              = w_tag_reg.qr;
        node.col              = w_tag_reg.qc[CELL_COL_BITS-1:0];
        node.own_label        = FIELD_BITS'(own);
        node.downstream_label = down;
        node.inflow_count     = cnt;
        node.tributary        = trib;
        node.trib_overflow    = cnt > 4'd4;
    end

    always_comb
    begin
        if (shift)
            w_valid_next = 1'b1;
        else if (w_adv)
            w_valid_next = 1'b0;
        else
            w_valid_next = w_valid_reg;
        if (w_adv)
            c_valid_next = 1'b1;
        else if (out_ready)
            c_valid_next = 1'b0;
        else
            c_valid_next = c_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            w_valid_reg <= w_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            win_lab_reg[0] <= win_lab_reg[1];
            win_lab_reg[1] <= win_lab_reg[2];
            win_lab_reg[2] <= in_lab;
            win_dir_reg[0] <= win_dir_reg[1];
            win_dir_reg[1] <= win_dir_reg[2];
            win_dir_reg[2] <= in_dir;
            w_tag_reg      <= in_tag;
        end
        if (w_adv)
            c_node_reg <= node;
    end

    assign out_valid = c_valid_reg;
    assign out_node  = c_node_reg;

endmodule

### hdl/srnf_node_out.sv
// ============================================================================
// srnf_node_out
// Spring and outlet counters, error flag and the output word register.
// ============================================================================
module srnf_node_out
    import srnf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  node_t                    in_node,
    input  logic [15:0]              stream_limit,
    input  logic                     restart,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    logic                     o_valid_reg;
    logic                     o_valid_next;
    logic [OUT_DATA_BITS-1:0] o_data_reg;
    logic [15:0]              spring_total_reg;
    logic [15:0]              spring_total_next;
    logic [15:0]              outlet_total_reg;
    logic [15:0]              outlet_total_next;

    logic                     o_free;
    logic                     take;
    logic                     err;
    logic                     is_spring;
    logic [OUT_DATA_BITS-1:0] word;

    assign o_free   = !o_valid_reg || m_axis_tready;
    assign in_ready = o_free;
    assign take     = in_valid && o_free;
    assign is_spring = in_node.inflow_count == '0;

    always_comb
    begin
        err               = in_node.trib_overflow;
        spring_total_next = spring_total_reg;
        outlet_total_next = outlet_total_reg;
        if (take && in_node.produce)
        begin
            if (in_node.own_label != in_node.downstream_label)
            begin
                if (outlet_total_reg >= stream_limit)
                    err = 1'b1;
                else if (in_node.downstream_label == '0)
                    outlet_total_next = outlet_total_reg + 16'd1;
            end
            if (is_spring)
            begin
                if (spring_total_reg >= stream_limit)
                    err = 1'b1;
                else
                    spring_total_next = spring_total_reg + 16'd1;
            end
        end
        // drop the frame totals once the last cell has been counted
        if (restart || (take && in_node.frame_last))
        begin
            spring_total_next = '0;
            outlet_total_next = '0;
        end
        o_valid_next = o_free ? (in_valid && in_node.produce) : o_valid_reg;
        word = {6'b0, err,
                in_node.tributary[3], in_node.tributary[2],
                in_node.tributary[1], in_node.tributary[0],
                in_node.inflow_count, is_spring,
                in_node.downstream_label, in_node.own_label,
                in_node.col, in_node.row};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg      <= 1'b0;
            spring_total_reg <= '0;
            outlet_total_reg <= '0;
        end
        else
        begin
            o_valid_reg      <= o_valid_next;
            spring_total_reg <= spring_total_next;
            outlet_total_reg <= outlet_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            o_data_reg <= word;
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;

endmodule

### hdl/srnf_port_checker.sv
// ============================================================================
// srnf_port_checker
// Port-level checks of the node finder, bound to the top level.
// ============================================================================
module srnf_port_checker
    import srnf_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [APB_ADDR_BITS-1:0] paddr,
    input logic [APB_DATA_BITS-1:0] pwdata,
    input logic [APB_DATA_BITS-1:0] prdata
);

    // hold a stalled output word
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("m_axis_tdata changed while stalled");

    // input back-pressure only comes from a stalled output
    a_ready_from_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("s_axis_tready low without output stall");

    // written row count reads back
    a_row_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && paddr[3:2] == REG_ROW_COUNT)
        && (paddr[3:2] == REG_ROW_COUNT)
        |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("row_count readback mismatch");

endmodule

bind stream_raster_node_finder_unit srnf_port_checker u_port_checker (.*);
